// ===== rtl/core/salru_pkg.sv =====
`default_nettype none
package salru_pkg;

  // default geometry
  localparam int MAX_SET_BITS_DEF = 8;
  localparam int WAYS_DEF         = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int SET_BITS_W    = 4;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_CFG_W    = 4;

  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 4'd4;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [WAYS_CFG_W-1:0]    WAYS_IN_USE_RST = 4'd1;

  // result field widths
  localparam int OUTCOME_W  = 2;
  localparam int WAY_OUT_W  = 3;
  localparam int SET_OUT_W  = 8;

  // shift amount for tag extraction: offset plus set bits
  localparam int TSHIFT_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/salru_ram.sv =====
`default_nettype none
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/salru_split.sv =====
`default_nettype none
module salru_split #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic [ADDR_WIDTH-1:0]                address,
  input  wire logic [salru_pkg::SET_BITS_W-1:0]     set_bits,
  input  wire logic [salru_pkg::OFFSET_BITS_W-1:0]  offset_bits,
  output logic      [MAX_SET_BITS-1:0]              set_idx,
  output logic      [ADDR_WIDTH-1:0]                tag
);

  logic [salru_pkg::SET_BITS_W-1:0] sb;
  logic [salru_pkg::TSHIFT_W-1:0]   tshift;
  logic [ADDR_WIDTH-1:0]            shifted;
  logic [MAX_SET_BITS-1:0]          set_mask;

  always_comb begin
    // set bits saturate at the configured maximum
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = salru_pkg::SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb = set_bits;
    end
    tshift   = salru_pkg::TSHIFT_W'(offset_bits) + salru_pkg::TSHIFT_W'(sb);
    // shifts by the full width or more give zero
    tag      = address >> tshift;
    shifted  = address >> offset_bits;
    set_mask = ~({MAX_SET_BITS{1'b1}} << sb);
    set_idx  = shifted[MAX_SET_BITS-1:0] & set_mask;
  end

endmodule
`default_nettype wire

// ===== rtl/core/salru_way_logic.sv =====
`default_nettype none
module salru_way_logic #(
  parameter int WAYS  = salru_pkg::WAYS_DEF,
  parameter int TAG_W = salru_pkg::ADDR_WIDTH_DEF,
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int ENTRY_W = 1 + TAG_W + WAY_W,
  localparam int ROW_W   = WAYS * ENTRY_W
) (
  input  wire logic [ROW_W-1:0]                 rd_row,
  input  wire logic [TAG_W-1:0]                 tag,
  input  wire logic [salru_pkg::WAYS_CFG_W-1:0] ways_in_use,
  output logic      [ROW_W-1:0]                 wr_row,
  output salru_pkg::outcome_t                   outcome,
  output logic      [WAY_W-1:0]                 way_sel
);

  localparam logic [WAY_W-1:0] RANK_MAX = WAY_W'(WAYS - 1);

  logic [WAYS-1:0]  in_use;
  logic [WAYS-1:0]  valid;
  logic [TAG_W-1:0] tags  [WAYS];
  logic [WAY_W-1:0] ranks [WAYS];

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             empty;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] best_rank;
  logic [WAY_W-1:0] limit_rank;

  logic             n_valid [WAYS];
  logic [TAG_W-1:0] n_tag   [WAYS];
  logic [WAY_W-1:0] n_rank  [WAYS];

  // unpack row: {valid, tag, rank} per way
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid[w]  = rd_row[w*ENTRY_W + ENTRY_W - 1];
      tags[w]   = rd_row[w*ENTRY_W + WAY_W +: TAG_W];
      ranks[w]  = rd_row[w*ENTRY_W +: WAY_W];
      in_use[w] = (w == 0) || (int'(ways_in_use) > w);
    end
  end

  // first matching way, first empty way, oldest way (ties to lowest)
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && in_use[w] && valid[w] && (tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!empty && in_use[w] && !valid[w]) begin
        empty     = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
    best_rank = ranks[0];
    vic_way   = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (ranks[w] > best_rank)) begin
        best_rank = ranks[w];
        vic_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if (hit) begin
      outcome = salru_pkg::OUT_HIT;
      way_sel = hit_way;
    end else if (empty) begin
      outcome = salru_pkg::OUT_FILL;
      way_sel = empty_way;
    end else begin
      outcome = salru_pkg::OUT_EVICT;
      way_sel = vic_way;
    end
    limit_rank = ranks[way_sel];
  end

  // recency update and line install
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      n_valid[w] = valid[w];
      n_tag[w]   = tags[w];
      n_rank[w]  = ranks[w];
      if (WAY_W'(w) == way_sel) begin
        n_valid[w] = 1'b1;
        n_tag[w]   = tag;
        n_rank[w]  = '0;
      end else if (in_use[w] && valid[w] && (!hit || (ranks[w] < limit_rank)) &&
                   (ranks[w] < RANK_MAX)) begin
        n_rank[w] = ranks[w] + 1'b1;
      end
      wr_row[w*ENTRY_W +: ENTRY_W] = {n_valid[w], n_tag[w], n_rank[w]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/set_associative_lru_cache_lookup_core.sv =====
`default_nettype none
// Set-associative cache tag lookup with exact LRU replacement. Each input beat carries one
// byte address; the set index and tag are cut from it using the offset_bits and set_bits
// registers, and the tag is matched against the first ways_in_use ways of that set. A hit
// makes the line most recent; a miss fills the lowest free way or evicts the oldest one.
// One result beat per input beat gives the outcome (hit, fill, evict), the way and the set.
// All lines of a set sit in one row of a single-port-write, registered-read memory: the
// row is read in the cycle the address is taken, then compared, updated and written back
// once the output register can take the result. No new address is taken until the last
// one is written back; a waiting result in the output register does not block the next read,
// only the write-back of the item after it. After reset the store is cleared row by row
// while in_stall stays high; config writes are taken at any time but must only be issued
// while the block is idle.
module set_associative_lru_cache_lookup_core #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = salru_pkg::WAYS_DEF,
  parameter int ADDR_WIDTH   = salru_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config write port
  input  wire logic                                cfg_we,
  input  wire logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // address channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ADDR_WIDTH-1:0]               in_address,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [salru_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic      [salru_pkg::WAY_OUT_W-1:0]     out_way_used,
  output logic      [salru_pkg::SET_OUT_W-1:0]     out_set_used
);

  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W  = 1 + ADDR_WIDTH + WAY_W;
  localparam int ROW_W    = WAYS * ENTRY_W;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;

  // config registers
  logic [salru_pkg::SET_BITS_W-1:0]    set_bits_r;
  logic [salru_pkg::OFFSET_BITS_W-1:0] offset_bits_r;
  logic [salru_pkg::WAYS_CFG_W-1:0]    ways_in_use_r;

  // control
  salru_pkg::state_t       state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] clr_idx_r;
  logic                    clr_last;
  logic                    in_accept;
  logic                    lookup_go;

  // item held between read and write-back
  logic [MAX_SET_BITS-1:0] set_r;
  logic [ADDR_WIDTH-1:0]   tag_r;

  // address split
  logic [MAX_SET_BITS-1:0] split_set;
  logic [ADDR_WIDTH-1:0]   split_tag;

  // memory port
  logic                    ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [ROW_W-1:0]        ram_rdata;

  // lookup result
  logic [ROW_W-1:0]        upd_row;
  salru_pkg::outcome_t     upd_outcome;
  logic [WAY_W-1:0]        upd_way;
  logic [WAY_W+salru_pkg::WAY_OUT_W-1:0]        way_ext;
  logic [MAX_SET_BITS+salru_pkg::SET_OUT_W-1:0] set_ext;

  // output register
  logic                               out_valid_r;
  logic [salru_pkg::OUTCOME_W-1:0]    out_outcome_r;
  logic [salru_pkg::WAY_OUT_W-1:0]    out_way_used_r;
  logic [salru_pkg::SET_OUT_W-1:0]    out_set_used_r;

  // config writes; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= salru_pkg::SET_BITS_RST;
      offset_bits_r <= salru_pkg::OFFSET_BITS_RST;
      ways_in_use_r <= salru_pkg::WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        salru_pkg::CFG_SET_BITS:    set_bits_r    <= cfg_wdata[salru_pkg::SET_BITS_W-1:0];
        salru_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        salru_pkg::CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata[salru_pkg::WAYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  salru_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_split (
    .address     (in_address),
    .set_bits    (set_bits_r),
    .offset_bits (offset_bits_r),
    .set_idx     (split_set),
    .tag         (split_tag)
  );

  // one row per set, all ways side by side
  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (split_set),
    .rdata (ram_rdata)
  );

  salru_way_logic #(
    .WAYS  (WAYS),
    .TAG_W (ADDR_WIDTH)
  ) u_way_logic (
    .rd_row      (ram_rdata),
    .tag         (tag_r),
    .ways_in_use (ways_in_use_r),
    .wr_row      (upd_row),
    .outcome     (upd_outcome),
    .way_sel     (upd_way)
  );

  assign clr_last  = (clr_idx_r == {MAX_SET_BITS{1'b1}});
  // write-back waits while the previous result is still held
  assign lookup_go = (state_r == salru_pkg::ST_LOOKUP) && (!out_valid_r || !out_stall);
  assign in_accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salru_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = salru_pkg::ST_LOOKUP;
        end
      end
      salru_pkg::ST_LOOKUP: begin
        if (lookup_go) begin
          state_nxt = salru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = salru_pkg::ST_CLEAR;
    endcase
  end

  // state outputs: read on accept, write on clear sweep or write-back
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = upd_row;
    case (state_r)
      salru_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      salru_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      salru_pkg::ST_LOOKUP: begin
        ram_we = lookup_go;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= salru_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == salru_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // hold set and tag for the write-back cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r <= split_set;
      tag_r <= split_tag;
    end
  end

  // result fields are the low bits of way and set
  assign way_ext = {{salru_pkg::WAY_OUT_W{1'b0}}, upd_way};
  assign set_ext = {{salru_pkg::SET_OUT_W{1'b0}}, set_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (lookup_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      out_outcome_r  <= upd_outcome;
      out_way_used_r <= way_ext[salru_pkg::WAY_OUT_W-1:0];
      out_set_used_r <= set_ext[salru_pkg::SET_OUT_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_outcome  = out_outcome_r;
  assign out_way_used = out_way_used_r;
  assign out_set_used = out_set_used_r;

`ifndef SYNTHESIS
  // a row is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("row read and write in the same cycle");

  // no address taken during the clear sweep
  a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salru_pkg::ST_CLEAR) |-> in_stall)
    else $error("address taken while clearing");

  // every write-back leaves a result in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_go |=> out_valid_r)
    else $error("write-back without result");

  // a lookup cycle follows an accepted address or a stalled lookup
  a_lookup_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salru_pkg::ST_LOOKUP) |->
      ($past(in_accept) || ($past(state_r) == salru_pkg::ST_LOOKUP)))
    else $error("lookup without accepted address");
`endif

endmodule
`default_nettype wire

// ===== tb/lru_lookup_checker.sv =====
`default_nettype none
module lru_lookup_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic [63:0]                      in_address,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [salru_pkg::OUTCOME_W-1:0]  out_outcome,
  input  wire logic [salru_pkg::WAY_OUT_W-1:0]  out_way_used,
  input  wire logic [salru_pkg::SET_OUT_W-1:0]  out_set_used,
  output int                                    mismatch_count,
  output int                                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAYS      = salru_pkg::WAYS_DEF;
  localparam int NUM_LINES = (1 << salru_pkg::MAX_SET_BITS_DEF) * WAYS;

  typedef struct packed {
    salru_pkg::outcome_t                outcome;
    logic [salru_pkg::WAY_OUT_W-1:0]    way;
    logic [salru_pkg::SET_OUT_W-1:0]    set_idx;
  } lookup_t;

  // shadow copy of the tag store and of the geometry registers
  bit                                  tag_valid [NUM_LINES];
  logic [63:0]                         tag_store [NUM_LINES];
  logic [2:0]                          age_rank  [NUM_LINES];
  logic [salru_pkg::SET_BITS_W-1:0]    set_bits_q;
  logic [salru_pkg::OFFSET_BITS_W-1:0] offset_bits_q;
  logic [salru_pkg::WAYS_CFG_W-1:0]    ways_q;

  lookup_t expected_lookups [$];
  lookup_t got_lookup;
  lookup_t new_lookup;

  initial mismatch_count = 0;
  initial pending_results = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one access: split the address, look up the set, refresh lru ranks
  task automatic lookup_and_update(input logic [63:0] addr, output lookup_t res);
    int          sb;
    int          ob;
    int          nways;
    int          tsh;
    int          base;
    int          way_sel;
    int          w;
    int          limit;
    logic [63:0] tag;
    logic [63:0] set_full;
    bit          found;
    bit          free_found;
    logic [2:0]  oldest;
    sb = (set_bits_q > salru_pkg::MAX_SET_BITS_DEF) ? salru_pkg::MAX_SET_BITS_DEF :
                                                      int'(set_bits_q);
    ob = int'(offset_bits_q);
    nways = int'(ways_q);
    if (nways == 0) nways = 1;
    if (nways > WAYS) nways = WAYS;
    tsh = ob + sb;
    tag = (tsh >= 64) ? 64'd0 : (addr >> tsh);
    set_full = (addr >> ob) & ((64'd1 << sb) - 64'd1);
    base = int'(set_full[7:0]) * WAYS;
    found = 1'b0;
    way_sel = 0;
    for (w = 0; w < nways; w++) begin
      if (!found && tag_valid[base+w] && tag_store[base+w] == tag) begin
        found = 1'b1;
        way_sel = w;
      end
    end
    if (found) begin
      res.outcome = salru_pkg::OUT_HIT;
    end else begin
      free_found = 1'b0;
      for (w = 0; w < nways; w++) begin
        if (!free_found && !tag_valid[base+w]) begin
          free_found = 1'b1;
          way_sel = w;
        end
      end
      if (free_found) begin
        res.outcome = salru_pkg::OUT_FILL;
      end else begin
        // oldest rank wins, lowest way on a tie
        oldest = age_rank[base];
        way_sel = 0;
        for (w = 1; w < nways; w++) begin
          if (age_rank[base+w] > oldest) begin
            oldest = age_rank[base+w];
            way_sel = w;
          end
        end
        res.outcome = salru_pkg::OUT_EVICT;
      end
      tag_valid[base+way_sel] = 1'b1;
      tag_store[base+way_sel] = tag;
    end
    // hit ages only younger lines, a fill or eviction ages all of them
    limit = found ? int'(age_rank[base+way_sel]) : WAYS;
    for (w = 0; w < nways; w++) begin
      if (tag_valid[base+w] && w != way_sel && age_rank[base+w] < limit &&
          age_rank[base+w] < WAYS - 1)
        age_rank[base+w] = age_rank[base+w] + 3'd1;
    end
    age_rank[base+way_sel] = 3'd0;
    res.way = way_sel[salru_pkg::WAY_OUT_W-1:0];
    res.set_idx = set_full[salru_pkg::SET_OUT_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        tag_valid[i] = 1'b0;
        tag_store[i] = '0;
        age_rank[i] = '0;
      end
      set_bits_q = salru_pkg::SET_BITS_RST;
      offset_bits_q = salru_pkg::OFFSET_BITS_RST;
      ways_q = salru_pkg::WAYS_IN_USE_RST;
      expected_lookups.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          salru_pkg::CFG_SET_BITS:
            set_bits_q = cfg_wdata[salru_pkg::SET_BITS_W-1:0];
          salru_pkg::CFG_OFFSET_BITS:
            offset_bits_q = cfg_wdata[salru_pkg::OFFSET_BITS_W-1:0];
          salru_pkg::CFG_WAYS_IN_USE:
            ways_q = cfg_wdata[salru_pkg::WAYS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          flag_mismatch($sformatf("result beat with no access pending: outcome %0d way %0d set %0d",
                                  out_outcome, out_way_used, out_set_used));
        end else begin
          got_lookup = expected_lookups.pop_front();
          if (out_outcome !== got_lookup.outcome)
            flag_mismatch($sformatf("outcome %0d, expected %0d (set %0d)",
                                    out_outcome, got_lookup.outcome, got_lookup.set_idx));
          if (out_way_used !== got_lookup.way)
            flag_mismatch($sformatf("way_used %0d, expected %0d (set %0d)",
                                    out_way_used, got_lookup.way, got_lookup.set_idx));
          if (out_set_used !== got_lookup.set_idx)
            flag_mismatch($sformatf("set_used %0d, expected %0d",
                                    out_set_used, got_lookup.set_idx));
        end
      end
      if (in_valid && !in_stall) begin
        lookup_and_update(in_address, new_lookup);
        expected_lookups.push_back(new_lookup);
      end
    end
    pending_results <= expected_lookups.size();
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 240;   // long receiver hold-off
  localparam int QUIET_LIMIT     = 2000;  // covers the clear pass and the hold-off
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int WAYS            = salru_pkg::WAYS_DEF;

  // every block input starts at a known value
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  salru_pkg::cfg_idx_t cfg_index = salru_pkg::CFG_SET_BITS;
  logic [5:0]          cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic [63:0]         in_address = '0;
  logic                out_stall = 1'b0;

  wire logic           in_stall;
  wire logic           out_valid;
  wire logic [1:0]     out_outcome;
  wire logic [2:0]     out_way_used;
  wire logic [7:0]     out_set_used;

  int mismatch_count;
  int pending_results;

  // idle rates, in percent of cycles
  int src_idle_pct = 35;
  int sink_idle_pct = 58;

  // hold-off requests from the stimulus, served by the receiver process
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // geometry as last written, used to shape addresses
  int cur_sb = 4;
  int cur_ob = 4;
  int cur_ways = 1;

  always #4 clk = ~clk;

  set_associative_lru_cache_lookup_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_address   (in_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_outcome  (out_outcome),
    .out_way_used (out_way_used),
    .out_set_used (out_set_used)
  );

  lru_lookup_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_way_used    (out_way_used),
    .out_set_used    (out_set_used),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // result side: random stall, or a solid stretch when a hold-off is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // watchdog: too long with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("set_associative_lru_cache_lookup_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one address beat, with random idle cycles ahead of it; returns at the
  // falling edge after the beat is taken, valid still high
  task automatic send_beat(input logic [63:0] addr);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all three geometry registers with the block idle; the unused top
  // bits of the narrow registers get random values, the block must drop them
  task automatic set_geometry(input int sb, input int ob, input int ways);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= salru_pkg::CFG_SET_BITS;
    cfg_wdata <= {2'($urandom_range(0, 3)), 4'(sb)};
    @(negedge clk);
    cfg_index <= salru_pkg::CFG_OFFSET_BITS;
    cfg_wdata <= 6'(ob);
    @(negedge clk);
    cfg_index <= salru_pkg::CFG_WAYS_IN_USE;
    cfg_wdata <= {2'($urandom_range(0, 3)), 4'(ways)};
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_sb = sb & 15;
    cur_ob = ob & 63;
    cur_ways = ways & 15;
  endtask

  // mostly addresses from a few sets and a few tags per set, so hits, fills
  // and evictions all come up; the rest is fully random
  function automatic logic [63:0] shaped_addr();
    logic [63:0] raw;
    logic [63:0] set_part;
    logic [63:0] tag_part;
    int          sb;
    int          nways;
    int          tsh;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 12) return raw;
    sb = (cur_sb > 8) ? 8 : cur_sb;
    nways = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : cur_ways);
    set_part = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
    set_part = set_part & ((64'd1 << sb) - 64'd1);
    tag_part = 64'($urandom_range(0, nways + 2));
    tsh = cur_ob + sb;
    return (raw & ((64'd1 << cur_ob) - 64'd1)) | (set_part << cur_ob) |
           ((tsh >= 64) ? 64'd0 : (tag_part << tsh));
  endfunction

  initial begin : stimulus
    int p;
    int n;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: 16 sets, 16-byte lines, one way
    send_beat(64'h0000_0000_0000_0000);  // fill set 0
    send_beat(64'hFFFF_FFFF_FFFF_FFFF);  // fill set 15, every address bit high
    send_beat(64'h0000_0000_0000_0008);  // hit, same line
    send_beat(64'h0000_0000_0000_0100);  // one way only: evict
    send_beat(64'h0000_0000_0000_000F);  // evict back

    // two sets, byte lines, eight ways: tag 0 still sits in way 0 so the first
    // beat hits, the rest fill set 0 up; then a hit on an older line and an
    // eviction of the least recent way
    set_geometry(1, 0, 8);
    for (n = 0; n < 8; n++) send_beat(64'(n) << 1);
    send_beat(64'h0000_0000_0000_0002);
    send_beat(64'h0000_0000_0000_0010);

    // no set bits: a single set, and zero ways in use acts as one way
    set_geometry(0, 0, 0);
    send_beat(64'h0000_0000_0000_0008);
    send_beat(64'h0000_0000_0000_0009);

    // set bits above the maximum, ways above the array size, offset plus set
    // bits past 64: tag is always 0 and the set is the top address bit
    set_geometry(15, 63, 15);
    send_beat(64'h8000_0000_0000_0000);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(64'h0000_0000_0000_0000);

    // offset plus set bits exactly 64
    set_geometry(4, 60, 2);
    send_beat(64'hA000_0000_0000_0000);
    send_beat(64'hA123_4567_89AB_CDEF);

    // random part: extremes of the geometry first, then random settings
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_geometry(0, 0, 8);
        1: set_geometry(8, 56, 8);
        2: set_geometry(15, 63, 15);
        3: set_geometry(1, 0, 1);
        4: set_geometry(3, 5, 4);
        default: set_geometry($urandom_range(0, 15), $urandom_range(0, 63),
                              $urandom_range(0, 15));
      endcase
      // idle pattern: sender lighter first, then swapped, then none
      if (p == 3) begin
        src_idle_pct = 58;
        sink_idle_pct <= 35;
      end else if (p == 6) begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver holds off while addresses keep coming, so the block backs up
        if (p == 1 && n == 10) hold_requests <= hold_requests + 1;
        send_beat(shaped_addr());
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("set_associative_lru_cache_lookup_core verification clean");
    end else begin
      $display("set_associative_lru_cache_lookup_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
